// File: hw/rtl/wsfr_pkg.sv
package wsfr_pkg;

   localparam int unsigned DATA_W = 8;
   localparam int unsigned CSR_W = 3;
   localparam int unsigned CSR_IDX_W = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_SKIP_HDR = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_LEN = 1'd1;

   localparam logic [7:0] FIN_MASK = 8'h80;
   localparam logic [7:0] OP_MASK = 8'h0F;
   localparam logic [6:0] LEN_MASK = 7'h7F;
   localparam logic [6:0] LEN_EXT16 = 7'h7E;
   localparam logic [6:0] LEN_EXT64 = 7'h7F;
   localparam logic [7:0] CHAR_CR = 8'h0D;
   localparam logic [7:0] CHAR_LF = 8'h0A;

   localparam logic [3:0] OP_CONT = 4'd0;
   localparam logic [3:0] OP_TEXT = 4'd1;
   localparam logic [3:0] OP_BIN = 4'd2;
   localparam logic [3:0] OP_CLOSE = 4'd8;
   localparam logic [3:0] OP_PING = 4'd9;
   localparam logic [3:0] OP_PONG = 4'd10;

   typedef enum logic [2:0] {
      ERR_NONE = 3'd0,
      ERR_DATA_IN_FRAG = 3'd1,
      ERR_STRAY_CONT = 3'd2,
      ERR_FRAG_PING = 3'd3,
      ERR_FRAG_PONG = 3'd4,
      ERR_CLOSE = 3'd5,
      ERR_BAD_OP = 3'd6,
      ERR_SHORT = 3'd7
   } err_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic data_valid;
      logic destination;
      logic frame_end;
      logic message_end;
      logic [2:0] error_code;
   } rsp_type;

endpackage

// File: hw/rtl/wsfr_if.sv
interface wsfr_req_if;
   logic valid;
   logic ready;
   logic [7:0] rx_byte;
   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface wsfr_rsp_if;
   logic valid;
   logic ready;
   logic [7:0] data_byte;
   logic data_valid;
   logic destination;
   logic frame_end;
   logic message_end;
   logic [2:0] error_code;
   modport source (output valid, output data_byte, output data_valid, output destination,
      output frame_end, output message_end, output error_code, input ready);
   modport sink (input valid, input data_byte, input data_valid, input destination,
      input frame_end, input message_end, input error_code, output ready);
endinterface

// File: hw/rtl/wsfr_front.sv
module wsfr_front
   import wsfr_pkg::*;
#(
   parameter int unsigned LENGTH_BITS = 64
) (
   input  logic clock,
   input  logic reset,
   input  logic skip_hdr,
   input  logic [2:0] min_len,
   input  logic in_valid,
   output logic in_ready,
   input  logic [7:0] in_byte,
   output logic out_valid,
   input  logic out_full,
   output rsp_type out_rsp
);

   typedef enum logic [2:0] {
      PH_SKIP, PH_HDR0, PH_HDR1, PH_EXTLEN, PH_MASKKEY, PH_PAYLOAD
   } phase_type;

   localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

   phase_type phase_ff, phase_in;
   logic [1:0] blm_ff, blm_in;
   logic [3:0] op_ff, op_in;
   logic fin_ff, fin_in, msk_ff, msk_in;
   logic [3:0] hbc_ff, hbc_in;
   logic [63:0] rem_ff, rem_in;
   logic [31:0] key_ff, key_in;
   logic [1:0] pos_ff, pos_in;
   logic frag_ff, frag_in;
   logic [2:0] seen_ff, seen_in;
   logic halt_ff, halt_in;
   logic emit;
   rsp_type rsp;
   logic fire;

   assign in_ready = !out_full;
   assign fire = in_valid && in_ready;

   function automatic logic is_data(input logic [3:0] op);
      return op == OP_CONT || op == OP_TEXT || op == OP_BIN;
   endfunction

   always_comb begin
      logic [3:0] op;
      logic [6:0] raw;
      logic [63:0] r;
      logic [7:0] d;
      logic [2:0] err;
      logic start_pl, close;
      phase_type ph;
      phase_in = phase_ff; blm_in = blm_ff; op_in = op_ff; fin_in = fin_ff;
      msk_in = msk_ff; hbc_in = hbc_ff; rem_in = rem_ff; key_in = key_ff;
      pos_in = pos_ff; frag_in = frag_ff; seen_in = seen_ff; halt_in = halt_ff;
      emit = 1'b0; rsp = '0; start_pl = 1'b0; close = 1'b0;
      op = in_byte[3:0] & OP_MASK[3:0]; raw = in_byte[6:0] & LEN_MASK;
      r = '0; d = in_byte; err = ERR_NONE;
      ph = phase_ff;
      if (!halt_ff) begin
         if (ph == PH_SKIP && !skip_hdr) ph = PH_HDR0;
         unique case (ph)
            PH_SKIP: begin
               unique case (blm_ff)
                  2'd0: blm_in = (in_byte == CHAR_CR) ? 2'd1 : 2'd2;
                  2'd1: if (in_byte == CHAR_LF) begin
                     blm_in = 2'd0; phase_in = PH_HDR0;
                  end else blm_in = (in_byte == CHAR_CR) ? 2'd3 : 2'd2;
                  2'd2: blm_in = (in_byte == CHAR_CR) ? 2'd3 : 2'd2;
                  default: if (in_byte == CHAR_LF) blm_in = 2'd0;
                     else blm_in = (in_byte == CHAR_CR) ? 2'd3 : 2'd2;
               endcase
            end
            PH_HDR0: begin
               if (op == OP_TEXT || op == OP_BIN) begin
                  if (frag_ff) err = ERR_DATA_IN_FRAG;
               end else if (op == OP_CONT) begin
                  if (!frag_ff) err = ERR_STRAY_CONT;
               end else if (op == OP_PING) begin
                  if (!in_byte[7]) err = ERR_FRAG_PING;
               end else if (op == OP_PONG) begin
                  if (!in_byte[7]) err = ERR_FRAG_PONG;
               end else if (op == OP_CLOSE) err = ERR_CLOSE;
               else err = ERR_BAD_OP;
               if (err != ERR_NONE) begin
                  emit = 1'b1; rsp.error_code = err; halt_in = 1'b1;
               end else begin
                  if (op == OP_TEXT || op == OP_BIN) begin
                     seen_in = '0;
                     if (!in_byte[7]) frag_in = 1'b1;
                  end
                  op_in = op; fin_in = in_byte[7]; phase_in = PH_HDR1;
               end
            end
            PH_HDR1: begin
               msk_in = in_byte[7]; rem_in = '0;
               if (raw == LEN_EXT16) begin hbc_in = 4'd2; phase_in = PH_EXTLEN; end
               else if (raw == LEN_EXT64) begin hbc_in = 4'd8; phase_in = PH_EXTLEN; end
               else begin
                  rem_in = {57'd0, raw};
                  if (in_byte[7]) begin
                     hbc_in = 4'd4; key_in = '0; phase_in = PH_MASKKEY;
                  end else start_pl = 1'b1;
               end
            end
            PH_EXTLEN: begin
               r = {rem_ff[55:0], in_byte};
               rem_in = r; hbc_in = hbc_ff - 4'd1;
               if (hbc_ff == 4'd1) begin
                  if (LENGTH_BITS < 64 && (r >> LENGTH_BITS) != 64'd0)
                     rem_in = 64'(LEN_MAX);
                  if (msk_ff) begin
                     hbc_in = 4'd4; key_in = '0; phase_in = PH_MASKKEY;
                  end else start_pl = 1'b1;
               end
            end
            PH_MASKKEY: begin
               key_in = {key_ff[23:0], in_byte}; hbc_in = hbc_ff - 4'd1;
               if (hbc_ff == 4'd1) start_pl = 1'b1;
            end
            PH_PAYLOAD: begin
               if (msk_ff) begin
                  unique case (pos_ff)
                     2'd0: d = in_byte ^ key_ff[31:24];
                     2'd1: d = in_byte ^ key_ff[23:16];
                     2'd2: d = in_byte ^ key_ff[15:8];
                     default: d = in_byte ^ key_ff[7:0];
                  endcase
               end
               pos_in = pos_ff + 2'd1;
               if (is_data(op_ff)) begin
                  emit = 1'b1; rsp.data_byte = d; rsp.data_valid = 1'b1;
                  if (seen_ff != 3'd7) seen_in = seen_ff + 3'd1;
               end else if (op_ff == OP_PING) begin
                  emit = 1'b1; rsp.data_byte = d; rsp.data_valid = 1'b1;
                  rsp.destination = 1'b1;
               end
               rem_in = (rem_ff - 64'd1) & 64'(LEN_MAX);
               if (rem_in == 64'd0) close = 1'b1;
            end
            default: phase_in = PH_HDR0;
         endcase
         if (start_pl) begin
            pos_in = '0;
            if (rem_in == 64'd0) close = 1'b1;
            else phase_in = PH_PAYLOAD;
         end
         if (close) begin
            emit = 1'b1; rsp.frame_end = 1'b1; phase_in = PH_HDR0;
            if (is_data(op_ff) && fin_ff) begin
               rsp.message_end = 1'b1; frag_in = 1'b0;
               if (seen_in < min_len) begin
                  rsp.error_code = ERR_SHORT; halt_in = 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SKIP; blm_ff <= '0; op_ff <= '0; fin_ff <= 1'b0;
         msk_ff <= 1'b0; hbc_ff <= '0; rem_ff <= '0; key_ff <= '0; pos_ff <= '0;
         frag_ff <= 1'b0; seen_ff <= '0; halt_ff <= 1'b0;
      end else if (fire) begin
         phase_ff <= phase_in; blm_ff <= blm_in; op_ff <= op_in; fin_ff <= fin_in;
         msk_ff <= msk_in; hbc_ff <= hbc_in; rem_ff <= rem_in; key_ff <= key_in;
         pos_ff <= pos_in; frag_ff <= frag_in; seen_ff <= seen_in; halt_ff <= halt_in;
      end
   end

   assign out_valid = fire && emit;
   assign out_rsp = rsp;

   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      halt_ff |=> halt_ff) else $error("halt cleared");
   a_halt_quiet: assert property (@(posedge clock) disable iff (reset)
      halt_ff |-> !out_valid) else $error("result while halted");
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      out_full |-> !in_ready) else $error("accept while queue full");

endmodule

// File: hw/rtl/wsfr_queue.sv
module wsfr_queue
   import wsfr_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  rsp_type push_rsp,
   output logic full,
   output logic pop_valid,
   input  logic pop_ready,
   output rsp_type pop_rsp
);

   rsp_type mem_ff [2];
   logic wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   logic pop;

   assign pop = pop_valid && pop_ready;
   assign pop_valid = cnt_ff != 2'd0;
   assign full = cnt_ff == 2'd2;
   assign pop_rsp = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= push_rsp;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0; rp_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= !wp_ff;
         if (pop) rp_ff <= !rp_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push) else $error("queue overflow");
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3) else $error("queue count out of range");
   a_pop_count: assert property (@(posedge clock) disable iff (reset)
      (pop && !push) |=> cnt_ff == $past(cnt_ff) - 2'd1) else $error("count slip");

endmodule

// File: hw/rtl/websocket_frame_receiver_core.sv
// Channel  Dir  Payload                                        Accept
// req      in   rx_byte[7:0]                                   valid & ready
// rsp      out  data_byte, data_valid, destination, frame_end, valid & ready
//               message_end, error_code
// csr      in   csr_index[0], csr_wdata[2:0]                   csr_we
//
// One byte per clock while the queue has room: the parser updates all frame
// state in the accepting cycle; each result is registered in the queue on its way to rsp.
// A two-entry queue parts parser and output; req stalls only when it is full.
// Synchronous reset: skip handshake on, minimum length 3, parser at skip.
// After an error the parser halts and drops every byte until reset.
module websocket_frame_receiver_core
   import wsfr_pkg::*;
#(
   parameter int unsigned LENGTH_BITS = 64
) (
   input  logic clock,
   input  logic reset,
   wsfr_req_if.sink req,
   wsfr_rsp_if.source rsp,
   input  logic csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0] csr_wdata
);

   logic skip_ff;
   logic [2:0] min_len_ff;
   logic f_valid, q_full;
   rsp_type f_rsp, q_rsp;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         skip_ff <= 1'b1;
         min_len_ff <= 3'd3;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SKIP_HDR: skip_ff <= csr_wdata[0];
            default: min_len_ff <= csr_wdata;
         endcase
      end
   end

   // front: byte parser and classifier
   wsfr_front #(.LENGTH_BITS(LENGTH_BITS)) u_front (
      .clock(clock), .reset(reset), .skip_hdr(skip_ff), .min_len(min_len_ff),
      .in_valid(req.valid), .in_ready(req.ready), .in_byte(req.rx_byte),
      .out_valid(f_valid), .out_full(q_full), .out_rsp(f_rsp)
   );

   // back: result queue toward the sink
   wsfr_queue u_queue (
      .clock(clock), .reset(reset), .push(f_valid), .push_rsp(f_rsp),
      .full(q_full), .pop_valid(rsp.valid), .pop_ready(rsp.ready), .pop_rsp(q_rsp)
   );

   assign rsp.data_byte = q_rsp.data_byte;
   assign rsp.data_valid = q_rsp.data_valid;
   assign rsp.destination = q_rsp.destination;
   assign rsp.frame_end = q_rsp.frame_end;
   assign rsp.message_end = q_rsp.message_end;
   assign rsp.error_code = q_rsp.error_code;

endmodule

// File: tb/wsfr_checker.sv
`timescale 1ns / 1ps

module wsfr_checker
   import wsfr_pkg::*;
(
   input  logic clock,
   input  logic reset,
   wsfr_req_if req,
   wsfr_rsp_if rsp,
   input  logic csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0] csr_wdata,
   output int failures,
   output int pending
);

   typedef enum logic [2:0] {
      P_SKIP, P_HDR0, P_HDR1, P_EXTLEN, P_KEY, P_PAYLOAD
   } parse_phase_type;

   // config copy
   logic skip_cfg;
   logic [2:0] min_len_cfg;

   // parser copy
   parse_phase_type phase;
   logic [1:0] crlf_state;
   logic [3:0] frame_op;
   logic frame_fin;
   logic frame_masked;
   logic [3:0] hdr_left;
   logic [63:0] payload_left;
   logic [31:0] mask_key;
   logic [1:0] mask_pos;
   logic in_frag;
   logic [2:0] msg_len;
   logic halted;

   rsp_type expected_rsps[$];

   function automatic bit is_data(input logic [3:0] op);
      return op == OP_CONT || op == OP_TEXT || op == OP_BIN;
   endfunction

   function automatic void reset_parser();
      skip_cfg = 1'b1;
      min_len_cfg = 3'd3;
      phase = P_SKIP;
      crlf_state = 2'd0;
      frame_op = 4'd0;
      frame_fin = 1'b0;
      frame_masked = 1'b0;
      hdr_left = 4'd0;
      payload_left = '0;
      mask_key = '0;
      mask_pos = 2'd0;
      in_frag = 1'b0;
      msg_len = 3'd0;
      halted = 1'b0;
   endfunction

   function automatic void end_frame(inout rsp_type r);
      r.frame_end = 1'b1;
      if (is_data(frame_op) && frame_fin) begin
         r.message_end = 1'b1;
         in_frag = 1'b0;
         if (msg_len < min_len_cfg) begin
            r.error_code = ERR_SHORT;
            halted = 1'b1;
         end
      end
      phase = P_HDR0;
   endfunction

   // header done: go to payload, or finish an empty frame right here
   function automatic bit enter_payload(inout rsp_type r);
      mask_pos = 2'd0;
      if (payload_left == 0) begin
         r = '0;
         end_frame(r);
         return 1'b1;
      end
      phase = P_PAYLOAD;
      return 1'b0;
   endfunction

   // advances the parser by one received byte; returns 1 when a result is due
   function automatic bit parse_byte(input logic [7:0] b, output rsp_type r);
      logic [3:0] op;
      logic [2:0] err;
      logic [6:0] len7;
      logic [7:0] d;
      bit emit;
      r = '0;
      if (halted)
         return 1'b0;
      if (phase == P_SKIP) begin
         if (skip_cfg) begin
            case (crlf_state)
               2'd0: crlf_state = (b == CHAR_CR) ? 2'd1 : 2'd2;
               2'd1: begin
                  if (b == CHAR_LF) begin
                     crlf_state = 2'd0;
                     phase = P_HDR0;
                  end else
                     crlf_state = (b == CHAR_CR) ? 2'd3 : 2'd2;
               end
               2'd2: crlf_state = (b == CHAR_CR) ? 2'd3 : 2'd2;
               default: begin
                  if (b == CHAR_LF)
                     crlf_state = 2'd0;
                  else
                     crlf_state = (b == CHAR_CR) ? 2'd3 : 2'd2;
               end
            endcase
            return 1'b0;
         end
         phase = P_HDR0;
      end
      case (phase)
         P_HDR0: begin
            op = b[3:0] & OP_MASK[3:0];
            err = ERR_NONE;
            if (op == OP_TEXT || op == OP_BIN) begin
               if (in_frag) err = ERR_DATA_IN_FRAG;
            end else if (op == OP_CONT) begin
               if (!in_frag) err = ERR_STRAY_CONT;
            end else if (op == OP_PING) begin
               if (!b[7]) err = ERR_FRAG_PING;
            end else if (op == OP_PONG) begin
               if (!b[7]) err = ERR_FRAG_PONG;
            end else if (op == OP_CLOSE)
               err = ERR_CLOSE;
            else
               err = ERR_BAD_OP;
            if (err != ERR_NONE) begin
               r.error_code = err;
               halted = 1'b1;
               return 1'b1;
            end
            if (op == OP_TEXT || op == OP_BIN) begin
               msg_len = 3'd0;
               if (!b[7]) in_frag = 1'b1;
            end
            frame_op = op;
            frame_fin = b[7];
            phase = P_HDR1;
            return 1'b0;
         end
         P_HDR1: begin
            frame_masked = b[7];
            len7 = b[6:0];
            payload_left = '0;
            if (len7 == LEN_EXT16 || len7 == LEN_EXT64) begin
               hdr_left = (len7 == LEN_EXT16) ? 4'd2 : 4'd8;
               phase = P_EXTLEN;
               return 1'b0;
            end
            payload_left = {57'd0, len7};
            if (frame_masked) begin
               hdr_left = 4'd4;
               mask_key = '0;
               phase = P_KEY;
               return 1'b0;
            end
            return enter_payload(r);
         end
         P_EXTLEN: begin
            payload_left = {payload_left[55:0], b};
            hdr_left = hdr_left - 4'd1;
            if (hdr_left != 0)
               return 1'b0;
            if (frame_masked) begin
               hdr_left = 4'd4;
               mask_key = '0;
               phase = P_KEY;
               return 1'b0;
            end
            return enter_payload(r);
         end
         P_KEY: begin
            mask_key = {mask_key[23:0], b};
            hdr_left = hdr_left - 4'd1;
            if (hdr_left != 0)
               return 1'b0;
            return enter_payload(r);
         end
         P_PAYLOAD: begin
            d = b;
            emit = 1'b1;
            if (frame_masked)
               d = d ^ mask_key[31 - 8 * mask_pos -: 8];
            mask_pos = mask_pos + 2'd1;
            if (is_data(frame_op)) begin
               r.data_byte = d;
               r.data_valid = 1'b1;
               if (msg_len != 3'd7) msg_len = msg_len + 3'd1;
            end else if (frame_op == OP_PING) begin
               r.data_byte = d;
               r.data_valid = 1'b1;
               r.destination = 1'b1;
            end else
               emit = 1'b0;
            payload_left = payload_left - 64'd1;
            if (payload_left == 0) begin
               end_frame(r);
               return 1'b1;
            end
            return emit;
         end
         default: begin
            phase = P_HDR0;
            return 1'b0;
         end
      endcase
   endfunction

   initial begin
      failures = 0;
      pending = 0;
      reset_parser();
   end

   // every input changes at the rising edge only, so the falling edge
   // sees exactly what the next rising edge will accept
   always @(negedge clock) begin
      rsp_type got;
      rsp_type want;
      rsp_type next_rsp;
      if (reset) begin
         reset_parser();
         expected_rsps.delete();
      end else begin
         if (rsp.valid && rsp.ready) begin
            got.data_byte = rsp.data_byte;
            got.data_valid = rsp.data_valid;
            got.destination = rsp.destination;
            got.frame_end = rsp.frame_end;
            got.message_end = rsp.message_end;
            got.error_code = rsp.error_code;
            if (expected_rsps.size() == 0) begin
               $error("unexpected response %p", got);
               failures++;
            end else begin
               want = expected_rsps.pop_front();
               if (got.data_byte !== want.data_byte) begin
                  $error("data_byte exp %0h got %0h", want.data_byte, got.data_byte);
                  failures++;
               end
               if (got.data_valid !== want.data_valid) begin
                  $error("data_valid exp %0d got %0d", want.data_valid, got.data_valid);
                  failures++;
               end
               if (got.destination !== want.destination) begin
                  $error("destination exp %0d got %0d", want.destination, got.destination);
                  failures++;
               end
               if (got.frame_end !== want.frame_end) begin
                  $error("frame_end exp %0d got %0d", want.frame_end, got.frame_end);
                  failures++;
               end
               if (got.message_end !== want.message_end) begin
                  $error("message_end exp %0d got %0d", want.message_end, got.message_end);
                  failures++;
               end
               if (got.error_code !== want.error_code) begin
                  $error("error_code exp %0d got %0d", want.error_code, got.error_code);
                  failures++;
               end
            end
         end
         if (req.valid && req.ready) begin
            if (parse_byte(req.rx_byte, next_rsp))
               expected_rsps.push_back(next_rsp);
         end
         if (csr_we) begin
            if (csr_index == CSR_SKIP_HDR)
               skip_cfg = csr_wdata[0];
            else if (csr_index == CSR_MIN_LEN)
               min_len_cfg = csr_wdata[2:0];
         end
      end
      pending = expected_rsps.size();
   end

   final begin
      if (expected_rsps.size() != 0)
         $error("%0d responses never arrived", expected_rsps.size());
   end

endmodule

// File: tb/websocket_frame_receiver_core_tb.sv
`timescale 1ns / 1ps

module websocket_frame_receiver_core_tb;
   import wsfr_pkg::*;

   localparam int TIMEOUT_CYCLES = 5000;
   localparam int TARGET_BYTES = 1050;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0] csr_wdata = '0;

   int failures;
   int pending;
   int bytes_sent = 0;
   int idle_cycles = 0;
   bit quiet = 1'b0;       // last part of the run: no idling on either side
   bit hold_rsp = 1'b0;    // request for one long response hold-off
   bit skip_on;

   wsfr_req_if req ();
   wsfr_rsp_if rsp ();

   websocket_frame_receiver_core DUT (
      .clock(clock),
      .reset(reset),
      .req(req),
      .rsp(rsp),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   wsfr_checker checker_i (
      .clock(clock),
      .reset(reset),
      .req(req),
      .rsp(rsp),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .failures(failures),
      .pending(pending)
   );

   always #5 clock = ~clock;

   initial begin
      req.valid = 1'b0;
      req.rx_byte = 8'h00;
      rsp.ready = 1'b0;
   end

   // Watchdog: any cycle without a handshake on either channel counts.
   always @(negedge clock) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= TIMEOUT_CYCLES) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Response side: random ready bursts, one long hold-off on request,
   // always ready once the run is quiet.
   initial begin
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (quiet) begin
            rsp.ready <= 1'b1;
         end else if (hold_rsp) begin
            rsp.ready <= 1'b0;
            repeat (80) @(posedge clock);
            hold_rsp = 1'b0;
         end else begin
            rsp.ready <= 1'b1;
            repeat ($urandom_range(0, 10)) @(posedge clock);
            if ($urandom_range(0, 2) != 0) begin
               @(posedge clock);
               rsp.ready <= 1'b0;
               repeat ($urandom_range(0, 5)) @(posedge clock);
            end
         end
      end
   end

   // One request byte. Called at a rising edge, returns at the edge that took it.
   task automatic send_byte(input logic [7:0] b);
      bit taken;
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req.valid <= 1'b1;
      req.rx_byte <= b;
      do begin
         @(negedge clock);
         taken = req.ready;
         @(posedge clock);
      end while (!taken);
      bytes_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++)
         send_byte(s[i]);
   endtask

   // Builds and sends one frame. len_form: 0 = 7-bit, 1 = 16-bit, 2 = 64-bit length.
   task automatic send_frame(input logic [3:0] op, input bit fin, input int len,
                             input bit masked, input int len_form);
      logic [31:0] key;
      logic [63:0] len64;
      key = $urandom;
      len64 = 64'(len);
      send_byte({fin, 3'($urandom_range(0, 7)), op});
      if (len_form == 0)
         send_byte({masked, 7'(len)});
      else if (len_form == 1) begin
         send_byte({masked, LEN_EXT16});
         send_byte(len64[15:8]);
         send_byte(len64[7:0]);
      end else begin
         send_byte({masked, LEN_EXT64});
         for (int i = 7; i >= 0; i--)
            send_byte(len64[8 * i +: 8]);
      end
      if (masked)
         for (int i = 3; i >= 0; i--)
            send_byte(key[8 * i +: 8]);
      for (int i = 0; i < len; i++)
         send_byte(8'($urandom));
   endtask

   // random framing for a given length; long lengths need an extended form
   task automatic send_any_frame(input logic [3:0] op, input bit fin, input int len);
      send_frame(op, fin, len, 1'($urandom_range(0, 1)),
                 (len > 125) ? $urandom_range(1, 2) : $urandom_range(0, 2));
   endtask

   // Stop the sender and wait for every outstanding response, plus slack
   // for a byte that gives no response but may still be in flight.
   task automatic drain();
      req.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Random well-formed traffic: whole messages, possibly fragmented, with
   // control frames mixed in. Every message carries at least 7 bytes so the
   // short-message check never trips here.
   task automatic send_message();
      int frags;
      int total;
      int len;
      logic [3:0] op;
      frags = ($urandom_range(0, 2) == 0) ? $urandom_range(2, 4) : 1;
      total = 0;
      op = $urandom_range(0, 1) ? OP_TEXT : OP_BIN;
      for (int f = 0; f < frags; f++) begin
         len = ($urandom_range(0, 15) == 0) ? $urandom_range(126, 160) : $urandom_range(0, 12);
         if (f == frags - 1 && total + len < 7)
            len = 7 - total;
         total += len;
         send_any_frame((f == 0) ? op : OP_CONT, f == frags - 1, len);
         if ($urandom_range(0, 3) == 0)
            send_any_frame($urandom_range(0, 1) ? OP_PING : OP_PONG, 1'b1,
                           $urandom_range(0, 6));
      end
   endtask

   initial begin
      int err_kind;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Skip mode is decided once; it cannot be re-entered after framing starts.
      skip_on = 1'($urandom_range(0, 1));
      write_csr(CSR_SKIP_HDR, {2'b00, skip_on});
      write_csr(CSR_MIN_LEN, 3'd0);

      // Directed: handshake text with stray CRs, then text, binary, ping, pong and continuation frames.
      if (skip_on) begin
         send_text("HTTP/1.1 101 Switching\015\nUp: ws\015\015\n\015\015");
         send_text("\n\015\n");
      end
      send_frame(OP_TEXT, 1'b1, 0, 1'b0, 0);     // empty message
      send_frame(OP_BIN, 1'b1, 125, 1'b1, 0);    // largest 7-bit length
      send_frame(OP_PING, 1'b1, 3, 1'b1, 0);
      send_frame(OP_PING, 1'b1, 0, 1'b0, 0);     // empty ping
      send_frame(OP_PONG, 1'b1, 4, 1'b1, 0);     // pong payload is dropped
      send_frame(OP_PONG, 1'b1, 0, 1'b0, 2);
      send_frame(OP_TEXT, 1'b0, 2, 1'b0, 0);     // fragmented message
      send_frame(OP_PING, 1'b1, 1, 1'b0, 0);
      send_frame(OP_CONT, 1'b0, 0, 1'b1, 1);
      send_frame(OP_CONT, 1'b1, 3, 1'b0, 2);
      drain();

      // Random phases at several minimum lengths, skip toggled to show it
      // has no effect once framing is under way.
      for (int ph = 0; ph < 4; ph++) begin
         write_csr(CSR_MIN_LEN, (ph == 0) ? 3'd7 : (ph == 1) ? 3'd0 : 3'($urandom_range(0, 7)));
         write_csr(CSR_SKIP_HDR, {2'b00, ph[0]});
         while (bytes_sent < TARGET_BYTES * (ph + 1) / 4) begin
            send_message();
            if ($urandom_range(0, 30) == 0) begin
               // sender waits out every outstanding response
               req.valid <= 1'b0;
               @(posedge clock);
               while (pending != 0)
                  @(posedge clock);
            end
         end
         if (ph == 1) begin
            // response side stalls long while a big frame keeps coming
            hold_rsp = 1'b1;
            send_frame(OP_BIN, 1'b1, 200, 1'b1, 1);
         end
         drain();
      end

      // Final part: no idling, and one error that halts the parser.
      quiet = 1'b1;
      err_kind = $urandom_range(ERR_DATA_IN_FRAG, ERR_SHORT);
      if (err_kind == ERR_SHORT) begin
         write_csr(CSR_MIN_LEN, 3'd7);
         send_frame(OP_TEXT, 1'b1, 3, 1'b1, 0);
      end else if (err_kind == ERR_DATA_IN_FRAG) begin
         send_frame(OP_BIN, 1'b0, 2, 1'b0, 0);
         send_frame(OP_TEXT, 1'b1, 2, 1'b0, 0);
      end else if (err_kind == ERR_STRAY_CONT)
         send_frame(OP_CONT, 1'b1, 2, 1'b0, 0);
      else if (err_kind == ERR_FRAG_PING)
         send_frame(OP_PING, 1'b0, 2, 1'b0, 0);
      else if (err_kind == ERR_FRAG_PONG)
         send_frame(OP_PONG, 1'b0, 2, 1'b0, 0);
      else if (err_kind == ERR_CLOSE)
         send_frame(OP_CLOSE, 1'b1, 2, 1'b0, 0);
      else
         send_frame($urandom_range(0, 1) ? 4'($urandom_range(3, 7)) : 4'($urandom_range(11, 15)),
                    1'b1, 2, 1'b0, 0);
      // halted: these must produce nothing
      send_frame(OP_TEXT, 1'b1, 8, 1'b0, 0);

      req.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
      if (failures == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

// File: sim.f
hw/rtl/wsfr_pkg.sv
hw/rtl/wsfr_if.sv
hw/rtl/wsfr_front.sv
hw/rtl/wsfr_queue.sv
hw/rtl/websocket_frame_receiver_core.sv
tb/wsfr_checker.sv
tb/websocket_frame_receiver_core_tb.sv
